>>> design/mfe_pkg.sv
//==============================================================================
// mfe_pkg
// Shared types and constants for the max flow engine: datapath operation
// codes, status bundle and field widths.
//==============================================================================
`default_nettype none

package mfe_pkg;

    localparam int unsigned CAP_W       = 31;
    localparam int unsigned NODE_W      = 8;
    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned IN_TDATA_W  = 48;
    localparam int unsigned OUT_TDATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR   = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_COMPUTE = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    // one datapath operation per cycle
    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_FLOW_INIT,
        OP_BFS_INIT,
        OP_DEQ_RD,
        OP_DEQ_GET,
        OP_SCAN,
        OP_PAR_RD,
        OP_PAR_GET,
        OP_MIN,
        OP_W2_INIT,
        OP_SUB,
        OP_ADD_REV,
        OP_RESULT
    } op_t;

    typedef struct packed {
        logic clr_last;
        logic add_ok;
        logic cfg_ok;
        logic q_empty;
        logic u_is_dst;
        logic scan_last;
        logic w_is_src;
        logic out_full;
    } status_t;

endpackage

`default_nettype wire

>>> design/mfe_ctrl.sv
//==============================================================================
// mfe_ctrl
// Sequencer: clear sweep, edge add, and the search / augment loop.
//==============================================================================
`default_nettype none

module mfe_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [1:0]       func,
    input  wire mfe_pkg::status_t st,
    output logic                  in_ready,
    output mfe_pkg::op_t          op
);
    import mfe_pkg::*;

    typedef enum logic [18:0] {
        S_CLR    = 19'h00001,
        S_IDLE   = 19'h00002,
        S_ADD_RD = 19'h00004,
        S_ADD_WR = 19'h00008,
        S_FINIT  = 19'h00010,
        S_BINIT  = 19'h00020,
        S_DEQ    = 19'h00040,
        S_DGET   = 19'h00080,
        S_SCAN   = 19'h00100,
        S_FLUSH  = 19'h00200,
        S_W1RD   = 19'h00400,
        S_W1GET  = 19'h00800,
        S_W1MIN  = 19'h01000,
        S_W2INIT = 19'h02000,
        S_W2RD   = 19'h04000,
        S_W2GET  = 19'h08000,
        S_W2SUB  = 19'h10000,
        S_W2ADD  = 19'h20000,
        S_RES    = 19'h40000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                op = OP_CLR;
                if (st.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (accept)
                begin
                    case (func_t'(func))
                        FUNC_CLEAR:   state_next = S_CLR;
                        FUNC_ADD:     state_next = S_ADD_RD;
                        FUNC_COMPUTE: state_next = S_FINIT;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD:
            begin
                if (st.add_ok)
                begin
                    op         = OP_ADD_RD;
                    state_next = S_ADD_WR;
                end
                else
                    state_next = S_IDLE;
            end
            S_ADD_WR:
            begin
                op         = OP_ADD_WR;
                state_next = S_IDLE;
            end
            S_FINIT:
            begin
                op         = OP_FLOW_INIT;
                state_next = st.cfg_ok ? S_BINIT : S_RES;
            end
            S_BINIT:
            begin
                op         = OP_BFS_INIT;
                state_next = S_DEQ;
            end
            S_DEQ:
            begin
                if (st.q_empty)
                    state_next = S_RES;
                else
                begin
                    op         = OP_DEQ_RD;
                    state_next = S_DGET;
                end
            end
            S_DGET:
            begin
                op         = OP_DEQ_GET;
                state_next = st.u_is_dst ? S_W1RD : S_SCAN;
            end
            S_SCAN:
            begin
                op = OP_SCAN;
                if (st.scan_last)
                    state_next = S_FLUSH;
            end
            S_FLUSH:  state_next = S_DEQ;
            S_W1RD:
            begin
                op         = OP_PAR_RD;
                state_next = S_W1GET;
            end
            S_W1GET:
            begin
                op         = OP_PAR_GET;
                state_next = S_W1MIN;
            end
            S_W1MIN:
            begin
                op         = OP_MIN;
                state_next = st.w_is_src ? S_W2INIT : S_W1RD;
            end
            S_W2INIT:
            begin
                op         = OP_W2_INIT;
                state_next = S_W2RD;
            end
            S_W2RD:
            begin
                op         = OP_PAR_RD;
                state_next = S_W2GET;
            end
            S_W2GET:
            begin
                op         = OP_PAR_GET;
                state_next = S_W2SUB;
            end
            S_W2SUB:
            begin
                op         = OP_SUB;
                state_next = S_W2ADD;
            end
            S_W2ADD:
            begin
                op         = OP_ADD_REV;
                state_next = st.w_is_src ? S_BINIT : S_W2RD;
            end
            S_RES:
            begin
                if (!st.out_full)
                begin
                    op         = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

>>> design/mfe_dp.sv
//==============================================================================
// mfe_dp
// Datapath: residual matrix memory, search queue, parent table, visited
// bits, bottleneck and flow total, result register.
//==============================================================================
`default_nettype none

module mfe_dp #(
    parameter int unsigned NODES = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire mfe_pkg::op_t                     op,
    output mfe_pkg::status_t                      st,
    input  wire logic                             accept,
    input  wire logic [mfe_pkg::IN_TDATA_W-1:0]   item_data,
    input  wire logic                             cfg_we,
    input  wire logic                             cfg_addr,
    input  wire logic [mfe_pkg::NODE_W-1:0]       cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [mfe_pkg::CAP_W-1:0]             out_flow,
    output logic                                  out_sat
);
    import mfe_pkg::*;

    localparam int unsigned NW = $clog2(NODES);
    localparam int unsigned AW = 2 * NW;
    localparam int unsigned QW = NW + 1;

    // registers
    logic [NODE_W-1:0] src_reg, dst_reg, from_reg, to_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic [CAP_W-1:0]  total_reg, neck_reg;
    logic [NW-1:0]     u_reg, v_reg, w_reg, vcnt_reg, pend_v_reg;
    logic              pend_reg;
    logic [QW-1:0]     head_reg, tail_reg;
    logic [NODES-1:0]  visited_reg;
    logic [NODES-1:0]  src_mask;
    logic [AW-1:0]     clr_reg;
    logic              out_valid_reg, out_sat_reg;
    logic [CAP_W-1:0]  out_flow_reg;

    // memories
    logic [CAP_W-1:0] res_mem [0:(1<<AW)-1];
    logic [CAP_W-1:0] res_rdata_reg;
    logic [NW-1:0]    q_mem [0:NODES-1];
    logic [NW-1:0]    q_rdata_reg;
    logic [NW-1:0]    par_mem [0:NODES-1];
    logic [NW-1:0]    par_rdata_reg;

    // node index conversion
    logic [31:0] src_x, dst_x, from_x, to_x;
    logic [NW-1:0] src_i, dst_i, from_i, to_i;
    assign src_x  = 32'(src_reg);
    assign dst_x  = 32'(dst_reg);
    assign from_x = 32'(from_reg);
    assign to_x   = 32'(to_reg);
    assign src_i  = src_x[NW-1:0];
    assign dst_i  = dst_x[NW-1:0];
    assign from_i = from_x[NW-1:0];
    assign to_i   = to_x[NW-1:0];

    // search starts with only the source marked
    always_comb
    begin
        src_mask        = '0;
        src_mask[src_i] = 1'b1;
    end

    // saturating adds
    logic [CAP_W:0]   add_sum, rev_sum, tot_sum;
    logic [CAP_W-1:0] add_sat, rev_sat, tot_sat;
    assign add_sum = {1'b0, res_rdata_reg} + {1'b0, cap_reg};
    assign rev_sum = {1'b0, res_rdata_reg} + {1'b0, neck_reg};
    assign tot_sum = {1'b0, total_reg} + {1'b0, neck_reg};
    assign add_sat = add_sum[CAP_W] ? CAP_MAX : add_sum[CAP_W-1:0];
    assign rev_sat = rev_sum[CAP_W] ? CAP_MAX : rev_sum[CAP_W-1:0];
    assign tot_sat = tot_sum[CAP_W] ? CAP_MAX : tot_sum[CAP_W-1:0];

    // neighbor taken by the scan check stage
    logic take;
    assign take = pend_reg && !visited_reg[pend_v_reg] && (res_rdata_reg != '0);

    // residual port control
    logic             res_we;
    logic [AW-1:0]    res_waddr, res_raddr;
    logic [CAP_W-1:0] res_wdata;

    always_comb
    begin
        res_we    = 1'b0;
        res_waddr = {w_reg, v_reg};
        res_wdata = res_rdata_reg - neck_reg;
        res_raddr = {u_reg, vcnt_reg};
        case (op)
            OP_CLR:
            begin
                res_we    = 1'b1;
                res_waddr = clr_reg;
                res_wdata = '0;
            end
            OP_ADD_RD:  res_raddr = {from_i, to_i};
            OP_ADD_WR:
            begin
                res_we    = 1'b1;
                res_waddr = {from_i, to_i};
                res_wdata = add_sat;
            end
            OP_PAR_GET: res_raddr = {par_rdata_reg, v_reg};
            OP_SUB:
            begin
                res_we    = 1'b1;
                res_raddr = {v_reg, w_reg};
            end
            OP_ADD_REV:
            begin
                res_we    = 1'b1;
                res_waddr = {v_reg, w_reg};
                res_wdata = rev_sat;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (res_we)
            res_mem[res_waddr] <= res_wdata;
        res_rdata_reg <= res_mem[res_raddr];
    end

    // queue: seeded with the source, appended by the scan check
    always_ff @(posedge clk)
    begin
        if (op == OP_BFS_INIT)
            q_mem[0] <= src_i;
        else if (take && tail_reg < QW'(NODES))
            q_mem[tail_reg[NW-1:0]] <= pend_v_reg;
        q_rdata_reg <= q_mem[head_reg[NW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (take)
            par_mem[pend_v_reg] <= u_reg;
        par_rdata_reg <= par_mem[v_reg];
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg <= '0;
            dst_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == 1'b0)
                src_reg <= cfg_data;
            else
                dst_reg <= cfg_data;
        end
    end

    // input item latch
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_reg <= item_data[7:0];
            to_reg   <= item_data[15:8];
            cap_reg  <= item_data[46:16];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            visited_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= (op == OP_SCAN);
            if (op == OP_CLR)
                clr_reg <= clr_reg + 1'b1;
            if (op == OP_BFS_INIT)
            begin
                visited_reg <= src_mask;
                head_reg    <= '0;
                tail_reg    <= QW'(1);
            end
            else
            begin
                if (take)
                begin
                    visited_reg[pend_v_reg] <= 1'b1;
                    if (tail_reg < QW'(NODES))
                        tail_reg <= tail_reg + 1'b1;
                end
                if (op == OP_DEQ_RD)
                    head_reg <= head_reg + 1'b1;
            end
            if (op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (op == OP_SCAN)
        begin
            vcnt_reg   <= vcnt_reg + 1'b1;
            pend_v_reg <= vcnt_reg;
        end
        case (op)
            OP_FLOW_INIT: total_reg <= '0;
            OP_DEQ_GET:
            begin
                u_reg    <= q_rdata_reg;
                vcnt_reg <= '0;
                v_reg    <= dst_i;
                neck_reg <= CAP_MAX;
            end
            OP_PAR_GET: w_reg <= par_rdata_reg;
            OP_MIN:
            begin
                if (res_rdata_reg < neck_reg)
                    neck_reg <= res_rdata_reg;
                v_reg <= w_reg;
            end
            OP_W2_INIT:
            begin
                total_reg <= tot_sat;
                v_reg     <= dst_i;
            end
            OP_ADD_REV: v_reg <= w_reg;
            OP_RESULT:
            begin
                out_flow_reg <= total_reg;
                out_sat_reg  <= (total_reg == CAP_MAX);
            end
            default: ;
        endcase
    end

    always_comb
    begin
        st.clr_last  = &clr_reg;
        st.add_ok    = (from_x < NODES) && (to_x < NODES);
        st.cfg_ok    = (src_x < NODES) && (dst_x < NODES) && (src_reg != dst_reg);
        st.q_empty   = (head_reg == tail_reg);
        st.u_is_dst  = (q_rdata_reg == dst_i);
        st.scan_last = (32'(vcnt_reg) == NODES - 1);
        st.w_is_src  = (w_reg == src_i);
        st.out_full  = out_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_flow  = out_flow_reg;
    assign out_sat   = out_sat_reg;

endmodule

`default_nettype wire

>>> design/max_flow_engine.sv
//==============================================================================
// max_flow_engine
// Edmonds-Karp maximum flow over a residual capacity matrix held in memory.
//==============================================================================
// Items carry a function code in s_tuser: clear the matrix, add capacity to
// one edge, or compute the max flow from source_node to sink_node (only a
// compute returns a result). One item is worked at a time; s_tready is low
// while it runs. After reset and after a clear, the matrix is swept to zero,
// one entry a cycle. During a compute, each node dequeued by a breadth-first
// search scans its whole matrix row through the single memory read port, and
// each path found then gets a bottleneck pass and an update pass over its
// edges. The result waits in an output register, so the next item can be
// taken before it is read.
//==============================================================================
`default_nettype none

module max_flow_engine #(
    parameter int unsigned NODES = 256
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // from_node[7:0], to_node[15:8], capacity[46:16], zero pad
    input  wire logic [mfe_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func[1:0]
    input  wire logic [mfe_pkg::FUNC_W-1:0]         s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // flow[30:0], zero pad
    output logic [mfe_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // saturated[0]
    output logic                                    m_tuser,
    input  wire logic                               cfg_we,
    input  wire logic                               cfg_addr,
    input  wire logic [mfe_pkg::NODE_W-1:0]         cfg_data
);
    import mfe_pkg::*;

    op_t              op;
    status_t          st;
    logic             accept;
    logic [CAP_W-1:0] flow;

    assign accept = s_tvalid && s_tready;

    mfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .func     (s_tuser),
        .st       (st),
        .in_ready (s_tready),
        .op       (op)
    );

    mfe_dp #(
        .NODES (NODES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .st        (st),
        .accept    (accept),
        .item_data (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_flow  (flow),
        .out_sat   (m_tuser)
    );

    assign m_tdata = {1'b0, flow};

endmodule

`default_nettype wire

>>> verif/max_flow_checker.sv
`timescale 1ns / 1ps
//==============================================================================
// max_flow_checker
// Watches the item, result and register channels of the max flow engine.
// Keeps its own residual matrix and endpoints, works out the max flow for
// every compute item, and compares each result item in order.
//==============================================================================

module max_flow_checker
    import mfe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [FUNC_W-1:0]      s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [OUT_TDATA_W-1:0] m_tdata,
    input  wire logic                   m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic                   cfg_addr,
    input  wire logic [NODE_W-1:0]      cfg_data,
    output int                          fail_count,
    output int                          flows_pending
);

    localparam int N = 256;

    typedef struct packed {
        logic             saturated;
        logic [CAP_W-1:0] flow;
    } flow_result_t;

    logic [CAP_W-1:0] resid [0:N*N-1];
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    flow_result_t expected_flows[$];

    function automatic logic [CAP_W-1:0] cap_add(logic [CAP_W-1:0] a, logic [CAP_W-1:0] b);
        logic [CAP_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CAP_W] ? CAP_MAX : s[CAP_W-1:0];
    endfunction

    function automatic void clear_matrix();
        for (int i = 0; i < N*N; i++)
            resid[i] = '0;
    endfunction

    // repeated shortest-path search, leaves the matrix fully augmented
    function automatic flow_result_t max_flow(int s, int t);
        int q[N];
        bit seen[N];
        int par[N];
        int head, tail, u, v;
        bit found;
        logic [CAP_W-1:0] neck, total;
        flow_result_t r;
        total = '0;
        if (s != t) begin
            forever begin
                for (int i = 0; i < N; i++)
                    seen[i] = 0;
                head = 0;
                tail = 0;
                found = 0;
                seen[s] = 1;
                q[tail++] = s;
                while (head < tail && !found) begin
                    u = q[head++];
                    if (u == t)
                        found = 1;
                    else
                        for (v = 0; v < N; v++)
                            if (!seen[v] && resid[u*N+v] != 0) begin
                                seen[v] = 1;
                                par[v] = u;
                                q[tail++] = v;
                            end
                end
                if (!found)
                    break;
                neck = CAP_MAX;
                for (v = t; v != s; v = par[v])
                    if (resid[par[v]*N+v] < neck)
                        neck = resid[par[v]*N+v];
                for (v = t; v != s; v = par[v]) begin
                    u = par[v];
                    resid[u*N+v] = resid[u*N+v] - neck;
                    resid[v*N+u] = cap_add(resid[v*N+u], neck);
                end
                total = cap_add(total, neck);
            end
        end
        r.flow = total;
        r.saturated = (total == CAP_MAX);
        return r;
    endfunction

    initial
    begin
        fail_count = 0;
        src_node = '0;
        dst_node = 8'd255;
        clear_matrix();
    end

    assign flows_pending = expected_flows.size();

    always @(posedge clk)
    begin
        flow_result_t exp_r;
        int from, to;
        if (rst_n) begin
            if (cfg_we) begin
                if (cfg_addr == 1'b0)
                    src_node <= cfg_data;
                else
                    dst_node <= cfg_data;
            end
            if (s_tvalid && s_tready) begin
                from = s_tdata[7:0];
                to = s_tdata[15:8];
                case (func_t'(s_tuser))
                    FUNC_CLEAR: clear_matrix();
                    FUNC_ADD: resid[from*N+to] = cap_add(resid[from*N+to], s_tdata[46:16]);
                    FUNC_COMPUTE: expected_flows.push_back(max_flow(src_node, dst_node));
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_flows.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: tdata %h tuser %b",
                                 m_tdata, m_tuser);
                end else begin
                    exp_r = expected_flows.pop_front();
                    if (m_tdata != {1'b0, exp_r.flow} || m_tuser != exp_r.saturated) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("flow mismatch: expected %0d sat %b, got tdata %h sat %b",
                                     exp_r.flow, exp_r.saturated, m_tdata, m_tuser);
                    end
                end
            end
        end
    end

endmodule

>>> verif/max_flow_engine_test.sv
`timescale 1ns / 1ps
//==============================================================================
// max_flow_engine_test
// Drives clear, add, compute and no-op items into the max flow engine over
// a series of source/sink settings, with random idling on both sides and
// one long result hold-off. The checker predicts and compares results.
//==============================================================================

module max_flow_engine_test;
    import mfe_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [FUNC_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   cfg_we;
    logic                   cfg_addr;
    logic [NODE_W-1:0]      cfg_data;
    int                     fail_count;
    int                     flows_pending;
    int                     items_sent;
    bit                     quiet;
    bit                     held;
    logic [NODE_W-1:0]      graph_nodes[6];

    max_flow_engine DUT (.*);

    max_flow_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #200_000_000;
        $display("** max_flow_engine: FAILED **");
        $finish;
    end

    task automatic send_item(func_t f, int from, int to, logic [CAP_W-1:0] cap);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= f;
        s_tdata <= {1'b0, cap, to[7:0], from[7:0]};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    // endpoints change only once the engine has drained
    task automatic set_endpoints(int src, int dst);
        s_tvalid <= 0;
        @(posedge clk);
        while (flows_pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        while (!s_tready) @(posedge clk);
        cfg_we <= 1;
        cfg_addr <= 1'b0;
        cfg_data <= src[7:0];
        @(posedge clk);
        cfg_addr <= 1'b1;
        cfg_data <= dst[7:0];
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic logic [CAP_W-1:0] rand_cap();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CAP_MAX;
            2: return CAP_W'($urandom());
            3: return CAP_W'($urandom_range(1, 1 << 24));
            default: return CAP_W'($urandom_range(1, 1000));
        endcase
    endfunction

    initial
    begin
        int src, dst;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = FUNC_NOP;
        cfg_we = 0;
        cfg_addr = 0;
        cfg_data = '0;
        items_sent = 0;
        quiet = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset endpoints 0 -> 255
        send_item(FUNC_NOP, 255, 255, CAP_MAX);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        send_item(FUNC_ADD, 0, 255, CAP_MAX);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        // reverse entry is already full here
        send_item(FUNC_ADD, 0, 255, 5);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        send_item(FUNC_ADD, 0, 255, CAP_MAX);
        send_item(FUNC_ADD, 0, 255, CAP_MAX);
        send_item(FUNC_ADD, 0, 7, CAP_MAX);
        send_item(FUNC_ADD, 7, 255, CAP_MAX);
        send_item(FUNC_ADD, 7, 255, 0);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        send_item(FUNC_CLEAR, 0, 0, 0);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        set_endpoints(9, 9);
        send_item(FUNC_ADD, 9, 9, 100);
        send_item(FUNC_COMPUTE, 0, 0, 0);
        set_endpoints(255, 0);
        send_item(FUNC_ADD, 255, 3, 10);
        send_item(FUNC_ADD, 3, 0, 4);
        send_item(FUNC_ADD, 255, 0, 6);
        send_item(FUNC_COMPUTE, 0, 0, 0);

        for (int ph = 0; ph < 20; ph++) begin
            case (ph % 5)
                0: begin src = 0; dst = 255; end
                1: begin src = 255; dst = 0; end
                2: begin src = $urandom_range(0, 255); dst = src; end
                default: begin src = $urandom_range(0, 255); dst = $urandom_range(0, 255); end
            endcase
            set_endpoints(src, dst);
            if (ph == 4 || ph == 11 || ph == 17)
                send_item(FUNC_CLEAR, 0, 0, 0);
            graph_nodes[0] = src[7:0];
            graph_nodes[1] = dst[7:0];
            for (int i = 2; i < 6; i++)
                graph_nodes[i] = NODE_W'($urandom_range(0, 255));
            if (ph == 16)
                quiet = 1;
            for (int k = 0; k < 31; k++) begin
                case ($urandom_range(0, 11))
                    0: send_item(FUNC_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
                                 CAP_W'($urandom()));
                    1, 2: send_item(FUNC_COMPUTE, $urandom_range(0, 255),
                                    $urandom_range(0, 255), CAP_W'($urandom()));
                    3: send_item(FUNC_ADD, $urandom_range(0, 255), $urandom_range(0, 255),
                                 rand_cap());
                    default: send_item(FUNC_ADD, graph_nodes[$urandom_range(0, 5)],
                                       graph_nodes[$urandom_range(0, 5)], rand_cap());
                endcase
            end
            send_item(FUNC_COMPUTE, 0, 0, 0);
        end
        s_tvalid <= 0;

        @(posedge clk);
        while (flows_pending != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && flows_pending == 0)
            $display("** max_flow_engine: PASSED **");
        else
            $display("** max_flow_engine: FAILED **");
        $finish;
    end

    // result side: random stalls plus one long hold-off mid-run
    initial
    begin
        held = 0;
        m_tready = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (!quiet && !held && items_sent >= 300) begin
                m_tready <= 0;
                repeat (400) @(posedge clk);
                held = 1;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                m_tready <= 1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

endmodule
